/* design/tfn_pkg.sv */
// Shared types and constants for the triangle face normal unit.
package tfn_pkg;

	localparam int EDGE_W     = 17;
	localparam int PROD_W     = 34;
	localparam int CROSS_W    = 35;
	localparam int MAG_W      = 34;
	localparam int POS_W      = 6;
	localparam int TARGET_BIT = 30;
	localparam int NRM_W      = TARGET_BIT + 1;
	localparam int SQ_W       = 2 * NRM_W;
	localparam int SUM_W      = 64;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int FRAC_BITS  = 14;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int NUM_W      = NRM_W + FRAC_BITS + 1;
	localparam int SQRT_CELLS = ROOT_W;
	localparam int DIV_CELLS  = QUO_W;

	typedef struct packed {
		logic signed [15:0] vertex_a_x;
		logic signed [15:0] vertex_a_y;
		logic signed [15:0] vertex_a_z;
		logic signed [15:0] vertex_b_x;
		logic signed [15:0] vertex_b_y;
		logic signed [15:0] vertex_b_z;
		logic signed [15:0] vertex_c_x;
		logic signed [15:0] vertex_c_y;
		logic signed [15:0] vertex_c_z;
	} face_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               degenerate;
	} normal_t;

	typedef struct packed {
		logic                        valid;
		logic [2:0]                  neg;
		logic                        degen;
		logic [2:0][NRM_W-1:0]       mag;
	} side_t;

	typedef struct packed {
		side_t              side;
		logic [REM_W-1:0]   rem;
		logic [ROOT_W-1:0]  root;
		logic [SUM_W-1:0]   s;
	} sq_t;

	typedef struct packed {
		logic                    valid;
		logic [2:0]              neg;
		logic                    degen;
		logic [ROOT_W-1:0]       len;
		logic [2:0][ROOT_W-1:0]  rem;
		logic [2:0][QUO_W-1:0]   num;
		logic [2:0][QUO_W-1:0]   quo;
	} dv_t;

endpackage

/* design/tfn_ifs.sv */
// Valid/ready channel interfaces for faces and normals.
interface tfn_face_if;
	logic           valid;
	logic           ready;
	tfn_pkg::face_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tfn_normal_if;
	logic             valid;
	logic             ready;
	tfn_pkg::normal_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/triangle_face_normal_unit.sv */
// Top level: edge vectors, cross product, normalize, square root and divide chains.
// Throughput: one face per cycle; the pipeline moves as one and holds when the
// output register is full and not taken.
// The pipeline holds 32 square root cells and 15 divider cells, one result bit each.
// Reset: arst_n clears all valid bits asynchronously; payload is not reset.
module triangle_face_normal_unit (
	input  logic          clk,
	input  logic          arst_n,
	tfn_face_if.sink      face,
	tfn_normal_if.source  normal
);
	localparam int EW = tfn_pkg::EDGE_W;
	localparam int PW = tfn_pkg::PROD_W;
	localparam int CW = tfn_pkg::CROSS_W;
	localparam int MW = tfn_pkg::MAG_W;
	localparam int NW = tfn_pkg::NRM_W;

	logic adv;
	logic out_valid_q;
	tfn_pkg::normal_t out_q;

	assign adv          = !out_valid_q || normal.ready;
	assign face.ready   = adv;
	assign normal.valid = out_valid_q;
	assign normal.data  = out_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [CW-1:0] c_s3 [3];
	logic [MW-1:0] m_s4 [3];
	logic [2:0]    neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [MW-1:0] or_s4;
	logic [MW-1:0] m_s5 [3];
	logic [tfn_pkg::POS_W-1:0] pos_s5;
	logic          dg_s5, dg_s6, dg_s7, dg_s8;
	logic [NW-1:0] n_s6 [3];
	logic [NW-1:0] n_s7 [3];
	logic [NW-1:0] n_s8 [3];
	logic [tfn_pkg::SQ_W-1:0] sq_s7 [3];
	logic [tfn_pkg::SUM_W-1:0] sum_s8;
	logic [tfn_pkg::POS_W-1:0] pos_c;
	logic [MW-1:0] sh_c [3];
	logic signed [CW-1:0] mag_c [3];

	always_comb begin
		pos_c = '0;
		for (int i = 0; i < MW; i++) begin
			if (or_s4[i]) pos_c = tfn_pkg::POS_W'(i);
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag_c[j] = c_s3[j][CW-1] ? CW'(-c_s3[j]) : c_s3[j];
			if (pos_s5 > tfn_pkg::POS_W'(tfn_pkg::TARGET_BIT))
				sh_c[j] = m_s5[j] >> (pos_s5 - tfn_pkg::POS_W'(tfn_pkg::TARGET_BIT));
			else
				sh_c[j] = m_s5[j] << (tfn_pkg::POS_W'(tfn_pkg::TARGET_BIT) - pos_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= face.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e1_s1[0] <= EW'(face.data.vertex_b_x) - EW'(face.data.vertex_a_x);
			e1_s1[1] <= EW'(face.data.vertex_b_y) - EW'(face.data.vertex_a_y);
			e1_s1[2] <= EW'(face.data.vertex_b_z) - EW'(face.data.vertex_a_z);
			e2_s1[0] <= EW'(face.data.vertex_c_x) - EW'(face.data.vertex_a_x);
			e2_s1[1] <= EW'(face.data.vertex_c_y) - EW'(face.data.vertex_a_y);
			e2_s1[2] <= EW'(face.data.vertex_c_z) - EW'(face.data.vertex_a_z);
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			for (int j = 0; j < 3; j++) begin
				c_s3[j] <= CW'(p_s2[2*j]) - CW'(p_s2[2*j+1]);
				m_s4[j] <= mag_c[j][MW-1:0];
				neg_s4[j] <= c_s3[j][CW-1];
				m_s5[j] <= m_s4[j];
				n_s6[j] <= sh_c[j][NW-1:0];
				n_s7[j] <= n_s6[j];
				sq_s7[j] <= n_s6[j] * n_s6[j];
				n_s8[j] <= n_s7[j];
			end
			or_s4  <= mag_c[0][MW-1:0] | mag_c[1][MW-1:0] | mag_c[2][MW-1:0];
			pos_s5 <= pos_c;
			dg_s5  <= (or_s4 == '0);
			neg_s5 <= neg_s4; neg_s6 <= neg_s5; neg_s7 <= neg_s6; neg_s8 <= neg_s7;
			dg_s6  <= dg_s5;  dg_s7  <= dg_s6;  dg_s8  <= dg_s7;
			sum_s8 <= tfn_pkg::SUM_W'(sq_s7[0]) + tfn_pkg::SUM_W'(sq_s7[1])
			        + tfn_pkg::SUM_W'(sq_s7[2]);
		end
	end

	tfn_pkg::sq_t sq_chain [tfn_pkg::SQRT_CELLS+1];

	always_comb begin
		sq_chain[0].side.valid = v_s8;
		sq_chain[0].side.neg   = neg_s8;
		sq_chain[0].side.degen = dg_s8;
		for (int j = 0; j < 3; j++) sq_chain[0].side.mag[j] = n_s8[j];
		sq_chain[0].rem  = '0;
		sq_chain[0].root = '0;
		sq_chain[0].s    = sum_s8;
	end

	for (genvar k = 0; k < tfn_pkg::SQRT_CELLS; k++) begin : g_sqrt
		tfn_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .d(sq_chain[k]), .q(sq_chain[k+1])
		);
	end

	tfn_pkg::dv_t dv_chain [tfn_pkg::DIV_CELLS+1];
	tfn_pkg::dv_t dv_s9;
	tfn_pkg::sq_t sq_end;
	logic [tfn_pkg::NUM_W-1:0] num_c [3];

	assign sq_end = sq_chain[tfn_pkg::SQRT_CELLS];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			num_c[j] = tfn_pkg::NUM_W'({sq_end.side.mag[j], {tfn_pkg::FRAC_BITS{1'b0}}})
			         + tfn_pkg::NUM_W'(sq_end.root[tfn_pkg::ROOT_W-1:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s9.valid <= 1'b0;
		end else if (adv) begin
			dv_s9.valid <= sq_end.side.valid;
			dv_s9.neg   <= sq_end.side.neg;
			dv_s9.degen <= sq_end.side.degen;
			dv_s9.len   <= sq_end.root;
			for (int j = 0; j < 3; j++) begin
				dv_s9.rem[j] <= tfn_pkg::ROOT_W'(num_c[j][tfn_pkg::NUM_W-1:tfn_pkg::QUO_W]);
				dv_s9.num[j] <= num_c[j][tfn_pkg::QUO_W-1:0];
				dv_s9.quo[j] <= '0;
			end
		end
	end

	assign dv_chain[0] = dv_s9;

	for (genvar k = 0; k < tfn_pkg::DIV_CELLS; k++) begin : g_div
		tfn_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .d(dv_chain[k]), .q(dv_chain[k+1])
		);
	end

	tfn_pkg::dv_t dv_end;
	logic signed [15:0] comp_c [3];

	assign dv_end = dv_chain[tfn_pkg::DIV_CELLS];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (dv_end.degen)
				comp_c[j] = '0;
			else if (dv_end.neg[j])
				comp_c[j] = -16'(dv_end.quo[j]);
			else
				comp_c[j] = 16'(dv_end.quo[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.normal_x   <= comp_c[0];
			out_q.normal_y   <= comp_c[1];
			out_q.normal_z   <= comp_c[2];
			out_q.degenerate <= dv_end.degen;
		end
	end
endmodule

/* design/tfn_sqrt_cell.sv */
// One digit cell of the pipelined integer square root.
module tfn_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tfn_pkg::sq_t  d,
	output tfn_pkg::sq_t  q
);
	logic [tfn_pkg::REM_W+1:0] rem2;
	logic [tfn_pkg::REM_W+1:0] trial;
	tfn_pkg::sq_t              nxt;

	always_comb begin
		rem2  = {d.rem, d.s[tfn_pkg::SUM_W-1 -: 2]};
		trial = (tfn_pkg::REM_W+2)'({d.root, 2'b01});
		nxt   = d;
		nxt.s = {d.s[tfn_pkg::SUM_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			nxt.rem  = tfn_pkg::REM_W'(rem2 - trial);
			nxt.root = {d.root[tfn_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem2[tfn_pkg::REM_W-1:0];
			nxt.root = {d.root[tfn_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.side.valid <= 1'b0;
		end else if (en) begin
			q <= nxt;
		end
	end
endmodule

/* design/tfn_div_cell.sv */
// One quotient-bit cell of the three-lane restoring divider.
module tfn_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tfn_pkg::dv_t  d,
	output tfn_pkg::dv_t  q
);
	logic [tfn_pkg::ROOT_W:0] r2 [3];
	tfn_pkg::dv_t             nxt;

	always_comb begin
		nxt = d;
		for (int j = 0; j < 3; j++) begin
			r2[j] = {d.rem[j], d.num[j][tfn_pkg::QUO_W-1]};
			nxt.num[j] = {d.num[j][tfn_pkg::QUO_W-2:0], 1'b0};
			if (r2[j] >= {1'b0, d.len}) begin
				nxt.rem[j] = tfn_pkg::ROOT_W'(r2[j] - {1'b0, d.len});
				nxt.quo[j] = {d.quo[j][tfn_pkg::QUO_W-2:0], 1'b1};
			end else begin
				nxt.rem[j] = r2[j][tfn_pkg::ROOT_W-1:0];
				nxt.quo[j] = {d.quo[j][tfn_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid <= 1'b0;
		end else if (en) begin
			q <= nxt;
		end
	end
endmodule

/* design/tfn_checker.sv */
// Port-level assertions for the triangle face normal unit, bound to the top level.
module tfn_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input tfn_pkg::normal_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("normal changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("face ready does not follow output stall");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |->
		out_data.normal_x == 16'sd0 && out_data.normal_y == 16'sd0 &&
		out_data.normal_z == 16'sd0)
		else $error("degenerate normal not zero");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.degenerate |->
		out_data.normal_x != 16'sd0 || out_data.normal_y != 16'sd0 ||
		out_data.normal_z != 16'sd0)
		else $error("zero normal without degenerate flag");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384 &&
		out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384 &&
		out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384)
		else $error("normal component out of range");
endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(face.ready),
	.out_valid(normal.valid),
	.out_ready(normal.ready),
	.out_data(normal.data)
);

/* bench/tb_face_normal.sv */
// Testbench: random and directed faces checked against a bit-exact normal predictor.
`timescale 1ns / 1ps

module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tfn_face_if   face_ch ();
	tfn_normal_if normal_ch ();

	triangle_face_normal_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.face   (face_ch.sink),
		.normal (normal_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tfn_pkg::face_t   pending_faces[$];
	tfn_pkg::normal_t expected_normals[$];
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	bit      hold_send = 1'b0;
	int      errors = 0;
	int      faces_sent = 0;
	int      normals_seen = 0;
	int      degen_seen = 0;
	longint  cycles = 0;

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] scale_axis(longint unsigned v, longint unsigned len,
			bit neg);
		longint unsigned q;
		q = (v * 16384 + (len >> 1)) / len;
		if (q > 16384)
			q = 16384;
		return neg ? -$signed(16'(q)) : $signed(16'(q));
	endfunction

	function automatic tfn_pkg::normal_t face_normal(tfn_pkg::face_t f);
		longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
		longint unsigned mx, my, mz, m, s, len;
		int p;
		tfn_pkg::normal_t r;
		e1x = longint'(f.vertex_b_x) - longint'(f.vertex_a_x);
		e1y = longint'(f.vertex_b_y) - longint'(f.vertex_a_y);
		e1z = longint'(f.vertex_b_z) - longint'(f.vertex_a_z);
		e2x = longint'(f.vertex_c_x) - longint'(f.vertex_a_x);
		e2y = longint'(f.vertex_c_y) - longint'(f.vertex_a_y);
		e2z = longint'(f.vertex_c_z) - longint'(f.vertex_a_z);
		nx = e1y * e2z - e1z * e2y;
		ny = e1z * e2x - e1x * e2z;
		nz = e1x * e2y - e1y * e2x;
		mx = nx < 0 ? -nx : nx;
		my = ny < 0 ? -ny : ny;
		mz = nz < 0 ? -nz : nz;
		m = mx;
		if (my > m) m = my;
		if (mz > m) m = mz;
		r = '0;
		if (m == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		p = -1;
		while (m != 0) begin
			m >>= 1;
			p++;
		end
		if (p > 30) begin
			mx >>= (p - 30); my >>= (p - 30); mz >>= (p - 30);
		end else if (p < 30) begin
			mx <<= (30 - p); my <<= (30 - p); mz <<= (30 - p);
		end
		s = mx * mx + my * my + mz * mz;
		len = int_sqrt(s);
		if (len == 0)
			len = 1;
		r.normal_x = scale_axis(mx, len, nx < 0);
		r.normal_y = scale_axis(my, len, ny < 0);
		r.normal_z = scale_axis(mz, len, nz < 0);
		return r;
	endfunction

	function automatic logic [15:0] pick_coord(int mode);
		case (mode)
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_face(tfn_pkg::face_t f);
		pending_faces = {pending_faces, f};
	endtask

	task automatic push_coords(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz);
		tfn_pkg::face_t f;
		f.vertex_a_x = 16'(ax); f.vertex_a_y = 16'(ay); f.vertex_a_z = 16'(az);
		f.vertex_b_x = 16'(bx); f.vertex_b_y = 16'(by); f.vertex_b_z = 16'(bz);
		f.vertex_c_x = 16'(cx); f.vertex_c_y = 16'(cy); f.vertex_c_z = 16'(cz);
		push_face(f);
	endtask

	task automatic fill_random(int count);
		tfn_pkg::face_t f;
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 9);
			if (mode < 2) begin
				f.vertex_a_x = pick_coord($urandom_range(0, 3));
				f.vertex_a_y = pick_coord($urandom_range(0, 3));
				f.vertex_a_z = pick_coord($urandom_range(0, 3));
				f.vertex_b_x = pick_coord($urandom_range(0, 3));
				f.vertex_b_y = pick_coord($urandom_range(0, 3));
				f.vertex_b_z = pick_coord($urandom_range(0, 3));
				f.vertex_c_x = pick_coord($urandom_range(0, 3));
				f.vertex_c_y = pick_coord($urandom_range(0, 3));
				f.vertex_c_z = pick_coord($urandom_range(0, 3));
			end else begin
				f = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
			end
			if (mode == 9) begin
				// collinear: C repeats B or A
				if ($urandom_range(0, 1)) begin
					f.vertex_c_x = f.vertex_b_x; f.vertex_c_y = f.vertex_b_y;
					f.vertex_c_z = f.vertex_b_z;
				end else begin
					f.vertex_c_x = f.vertex_a_x; f.vertex_c_y = f.vertex_a_y;
					f.vertex_c_z = f.vertex_a_z;
				end
			end
			push_face(f);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_ch.valid <= 1'b0;
			face_ch.data  <= '0;
		end else begin
			if (face_ch.valid && face_ch.ready) begin
				expected_normals = {expected_normals, face_normal(face_ch.data)};
				faces_sent++;
			end
			if (face_ch.valid && !face_ch.ready) begin
				// hold the transaction
			end else if (pending_faces.size() != 0 && !hold_send &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				face_ch.valid <= 1'b1;
				face_ch.data  <= pending_faces.pop_front();
			end else begin
				face_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		tfn_pkg::normal_t exp_n;
		if (!arst_n) begin
			normal_ch.ready <= 1'b0;
		end else begin
			cycles++;
			if (normal_ch.valid && normal_ch.ready) begin
				normals_seen++;
				if (expected_normals.size() == 0) begin
					$error("normal with no face pending");
					errors++;
				end else begin
					exp_n = expected_normals.pop_front();
					if (normal_ch.data.degenerate) degen_seen++;
					if (normal_ch.data.normal_x !== exp_n.normal_x) begin
						$error("normal_x expected %0d actual %0d", exp_n.normal_x,
							normal_ch.data.normal_x);
						errors++;
					end
					if (normal_ch.data.normal_y !== exp_n.normal_y) begin
						$error("normal_y expected %0d actual %0d", exp_n.normal_y,
							normal_ch.data.normal_y);
						errors++;
					end
					if (normal_ch.data.normal_z !== exp_n.normal_z) begin
						$error("normal_z expected %0d actual %0d", exp_n.normal_z,
							normal_ch.data.normal_z);
						errors++;
					end
					if (normal_ch.data.degenerate !== exp_n.degenerate) begin
						$error("degenerate expected %0b actual %0b", exp_n.degenerate,
							normal_ch.data.degenerate);
						errors++;
					end
				end
			end
			normal_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (cycles > 200000) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic drain();
		while (pending_faces.size() != 0 || face_ch.valid || expected_normals.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		// directed: axis-aligned, extremes, degenerate, sign mixes
		push_coords(0, 0, 0, 256, 0, 0, 0, 256, 0);
		push_coords(0, 0, 0, 0, 256, 0, 256, 0, 0);
		push_coords(0, 0, 0, 0, 256, 0, 0, 0, 256);
		push_coords(0, 0, 0, 0, 0, 256, 256, 0, 0);
		push_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
		push_coords(5, 6, 7, 5, 6, 7, 100, -3, 2);
		push_coords(0, 0, 0, 10, 20, 30, 20, 40, 60);
		push_coords(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
		push_coords(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
		push_coords(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768);
		push_coords(32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768, 32767);
		push_coords(0, 0, 0, 1, 0, 0, 0, 1, 0);
		push_coords(0, 0, 0, 1, 1, 0, 1, 0, 1);
		push_coords(0, 0, 0, 1, 2, 3, 4, 5, 6);
		push_coords(0, 0, 0, 256, 256, 256, -256, 256, 0);
		push_coords(-1, -1, -1, 0, 0, 0, 0, 0, 1);
		push_coords(100, 200, 300, -400, 500, -600, 700, -800, 900);
		push_coords(0, 0, 0, 32767, 1, 0, 1, 32767, 0);
		push_coords(0, 0, 0, 3, 0, 0, 0, 4, 5);
		push_coords(0, 0, 0, -32768, 0, 0, 0, -32768, 0);
		repeat (2) @(posedge clk);
		arst_n = 1'b1;
		send_idle_pct = 27; recv_idle_pct = 69;
		fill_random(380);
		drain();
		// pause the sender with the pipe empty, then resume
		hold_send = 1'b1;
		fill_random(20);
		repeat (20) @(posedge clk);
		hold_send = 1'b0;
		send_idle_pct = 69; recv_idle_pct = 27;
		fill_random(400);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		fill_random(400);
		drain();
		repeat (80) @(posedge clk);
		$display("%0d faces sent, %0d normals checked (%0d degenerate), three idle mixes",
			faces_sent, normals_seen, degen_seen);
		if (errors == 0 && expected_normals.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
